// ----- hw/rtl/bitmap_range_engine_assert.svh -----
// Assertion macros used by the checks in the engine's top level.
`ifndef BITMAP_RANGE_ENGINE_ASSERT_SVH
`define BITMAP_RANGE_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define BRG_ASSERT_IMPLY(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BRG_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/brg_pkg.sv -----
package brg_pkg;

  // Field widths of the command and result transfers.
  localparam int CMD_W   = 3;
  localparam int START_W = 12;
  localparam int COUNT_W = 13;
  localparam int TOTAL_W = 13;

  // Start plus count fits in SPAN_W bits; the byte index of any range end fits in BYTE_W.
  // SPAN_LIMIT is the farthest exclusive end that any command can reach.
  localparam int SPAN_W        = START_W + 2;
  localparam int SPAN_LIMIT    = (1 << START_W) + (1 << COUNT_W) - 2;
  localparam int BYTE_W        = SPAN_W - 3;
  localparam int MAX_CMD_BYTES = (SPAN_LIMIT + 7) / 8;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_SET             = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR           = 3'd1;
  localparam logic [CMD_W-1:0] CMD_COUNT_SET       = 3'd2;
  localparam logic [CMD_W-1:0] CMD_COUNT_CLEAR     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_COUNT_AND_SET   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_COUNT_AND_CLEAR = 3'd5;

  // Byte constants.
  localparam logic [7:0] BYTE_ONES = 8'hFF;
  localparam logic [2:0] LAST_BIT  = 3'h7;

  // Queue between the front and the back.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  // Number of set bits in each nibble value.
  localparam logic [2:0] NIBBLE_ONES [16] = '{
    3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
    3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4
  };

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [START_W-1:0] start_index;
    logic [COUNT_W-1:0] bit_count;
  } brg_in_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] bit_total;
    logic               range_clipped;
  } brg_out_t;

  // Decoded command handed from the front to the back.
  typedef struct packed {
    logic              empty;
    logic              clipped;
    logic              do_count;
    logic              count_zero;
    logic              do_write;
    logic              write_set;
    logic [BYTE_W-1:0] first_byte;
    logic [BYTE_W-1:0] last_byte;
    logic [2:0]        first_off;
    logic [2:0]        last_off;
  } brg_desc_t;

  // Queue status seen by its neighbors.
  typedef struct packed {
    logic full;
    logic empty;
  } brg_q_stat_t;

  function automatic logic [3:0] popcount8(input logic [7:0] b);
    popcount8 = 4'(NIBBLE_ONES[b[7:4]]) + 4'(NIBBLE_ONES[b[3:0]]);
  endfunction

endpackage

// ----- hw/rtl/brg_front.sv -----
module brg_front #(
  parameter int BITMAP_BITS = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  brg_pkg::brg_in_t    in_item,
  input  brg_pkg::brg_q_stat_t q_stat,
  output logic                push,
  output logic                stage_busy,
  output brg_pkg::brg_desc_t  desc
);
  import brg_pkg::*;

  localparam int LIMIT = (BITMAP_BITS < SPAN_LIMIT) ? BITMAP_BITS : SPAN_LIMIT;
  localparam logic [SPAN_W-1:0] LIMIT_V = SPAN_W'(LIMIT);

  logic              valid_r;
  logic              valid_nxt;
  brg_desc_t         desc_r;
  brg_desc_t         desc_nxt;

  logic              cmd_ok;
  logic              active;
  logic              start_past;
  logic [SPAN_W-1:0] start_ext;
  logic [SPAN_W-1:0] end_excl;
  logic [SPAN_W-1:0] eff_end;
  logic [SPAN_W-1:0] last_idx;

  // Decode the command, clip the range to the store and split it into byte bounds.
  always_comb begin
    desc_nxt   = '0;
    start_ext  = SPAN_W'(in_item.start_index);
    end_excl   = start_ext + SPAN_W'(in_item.bit_count);
    cmd_ok     = 1'b0;
    unique case (in_item.command)
      CMD_SET: begin
        cmd_ok             = 1'b1;
        desc_nxt.do_write  = 1'b1;
        desc_nxt.write_set = 1'b1;
      end
      CMD_CLEAR: begin
        cmd_ok            = 1'b1;
        desc_nxt.do_write = 1'b1;
      end
      CMD_COUNT_SET: begin
        cmd_ok            = 1'b1;
        desc_nxt.do_count = 1'b1;
      end
      CMD_COUNT_CLEAR: begin
        cmd_ok              = 1'b1;
        desc_nxt.do_count   = 1'b1;
        desc_nxt.count_zero = 1'b1;
      end
      CMD_COUNT_AND_SET: begin
        cmd_ok             = 1'b1;
        desc_nxt.do_count  = 1'b1;
        desc_nxt.do_write  = 1'b1;
        desc_nxt.write_set = 1'b1;
      end
      CMD_COUNT_AND_CLEAR: begin
        cmd_ok            = 1'b1;
        desc_nxt.do_count = 1'b1;
        desc_nxt.do_write = 1'b1;
      end
      default: begin
        cmd_ok = 1'b0;
      end
    endcase
    active              = cmd_ok && (in_item.bit_count != '0);
    start_past          = start_ext >= LIMIT_V;
    desc_nxt.clipped    = active && (end_excl > LIMIT_V);
    desc_nxt.empty      = !active || start_past;
    eff_end             = desc_nxt.clipped ? LIMIT_V : end_excl;
    last_idx            = eff_end - SPAN_W'(1);
    desc_nxt.first_byte = BYTE_W'(start_ext >> 3);
    desc_nxt.last_byte  = BYTE_W'(last_idx >> 3);
    desc_nxt.first_off  = start_ext[2:0];
    desc_nxt.last_off   = last_idx[2:0];
  end

  // One holding stage; it hands over as soon as the queue has room.
  assign push       = valid_r && !q_stat.full;
  assign stage_busy = valid_r && q_stat.full;
  assign desc       = desc_r;
  assign valid_nxt  = accept || (valid_r && !push);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      desc_r <= desc_nxt;
    end
  end

endmodule

// ----- hw/rtl/brg_queue.sv -----
module brg_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  brg_pkg::brg_desc_t   push_desc,
  input  logic                 pop,
  output brg_pkg::brg_desc_t   head_desc,
  output brg_pkg::brg_q_stat_t q_stat
);
  import brg_pkg::*;

  brg_desc_t          entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_nxt;
  logic [Q_PTR_W:0]   cnt_r;
  logic [Q_PTR_W:0]   cnt_nxt;
  logic               do_push;
  logic               do_pop;

  assign q_stat.full  = cnt_r == (Q_PTR_W + 1)'(Q_DEPTH);
  assign q_stat.empty = cnt_r == '0;
  assign head_desc    = entry_r[rd_ptr_r];
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;

  // Pointer and fill updates.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + (Q_PTR_W + 1)'(do_push) - (Q_PTR_W + 1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

// ----- hw/rtl/brg_back.sv -----
module brg_back #(
  parameter int BITMAP_BITS = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  brg_pkg::brg_q_stat_t q_stat,
  input  brg_pkg::brg_desc_t   head_desc,
  output logic                 pop,
  output logic                 clearing,
  output logic                 out_valid,
  output brg_pkg::brg_out_t    out_result
);
  import brg_pkg::*;

  // Bytes beyond the reach of any command are never stored.
  localparam int STORE_BYTES = (BITMAP_BITS + 7) / 8;
  localparam int MEM_BYTES   = (STORE_BYTES < MAX_CMD_BYTES) ? STORE_BYTES : MAX_CMD_BYTES;
  localparam int AW          = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_BYTES - 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_WAIT  = 2'd3;

  logic [7:0]         mem [MEM_BYTES];
  logic [7:0]         mem_q_r;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic [7:0]         mem_wd;

  logic [1:0]         state_r;
  logic [1:0]         state_nxt;
  logic [AW-1:0]      addr_r;
  logic [AW-1:0]      addr_nxt;
  logic [AW-1:0]      clr_addr_r;
  logic [AW-1:0]      clr_addr_nxt;
  brg_desc_t          cur_r;
  brg_desc_t          cur_nxt;
  logic [TOTAL_W-1:0] total_r;
  logic [TOTAL_W-1:0] total_nxt;
  logic [TOTAL_W-1:0] total_sum;
  logic               pend_r;
  logic               pend_nxt;
  logic               pend_first_r;
  logic               pend_first_nxt;
  logic               pend_last_r;
  logic               pend_last_nxt;
  logic [AW-1:0]      pend_addr_r;
  logic [AW-1:0]      pend_addr_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  brg_out_t           out_result_r;
  brg_out_t           out_result_nxt;

  logic [2:0]         lo_off;
  logic [2:0]         hi_off;
  logic [7:0]         byte_mask;
  logic [7:0]         counted;
  logic [3:0]         byte_ones;

  // Mask and count for the byte whose read data has just arrived.
  always_comb begin
    lo_off    = pend_first_r ? cur_r.first_off : 3'd0;
    hi_off    = pend_last_r ? cur_r.last_off : LAST_BIT;
    byte_mask = (BYTE_ONES >> lo_off) & (BYTE_ONES << (LAST_BIT - hi_off));
    counted   = cur_r.count_zero ? (byte_mask & ~mem_q_r) : (byte_mask & mem_q_r);
    byte_ones = cur_r.do_count ? popcount8(counted) : 4'd0;
    total_sum = total_r + TOTAL_W'(byte_ones);
  end

  // Sequencer: clear pass, command pickup, one byte read a cycle.
  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    clr_addr_nxt   = clr_addr_r;
    cur_nxt        = cur_r;
    total_nxt      = total_r;
    pend_nxt       = 1'b0;
    pend_first_nxt = 1'b0;
    pend_last_nxt  = 1'b0;
    pend_addr_nxt  = addr_r;
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result_r;
    pop            = 1'b0;
    mem_we         = 1'b0;
    mem_wa         = pend_addr_r;
    mem_wd         = cur_r.write_set ? (mem_q_r | byte_mask) : (mem_q_r & ~byte_mask);

    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr_r;
        mem_wd = '0;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          cur_nxt   = head_desc;
          total_nxt = '0;
          if (head_desc.empty) begin
            out_valid_nxt                = 1'b1;
            out_result_nxt.bit_total     = '0;
            out_result_nxt.range_clipped = head_desc.clipped;
          end else begin
            addr_nxt  = AW'(head_desc.first_byte);
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        pend_nxt       = 1'b1;
        pend_addr_nxt  = addr_r;
        pend_first_nxt = addr_r == AW'(cur_r.first_byte);
        pend_last_nxt  = addr_r == AW'(cur_r.last_byte);
        if (addr_r == AW'(cur_r.last_byte)) begin
          state_nxt = ST_WAIT;
        end else begin
          addr_nxt = addr_r + AW'(1);
        end
      end
      ST_WAIT: begin
        if (pend_r && pend_last_r) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase

    // Read-modify-write of the arriving byte and the final result.
    if (pend_r) begin
      total_nxt = total_sum;
      mem_we    = cur_r.do_write;
      if (pend_last_r) begin
        out_valid_nxt                = 1'b1;
        out_result_nxt.bit_total     = total_sum;
        out_result_nxt.range_clipped = cur_r.clipped;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r       <= addr_nxt;
    cur_r        <= cur_nxt;
    total_r      <= total_nxt;
    pend_first_r <= pend_first_nxt;
    pend_last_r  <= pend_last_nxt;
    pend_addr_r  <= pend_addr_nxt;
    out_result_r <= out_result_nxt;
  end

  // Bitmap memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q_r <= mem[addr_r];
  end

  assign clearing   = state_r == ST_CLEAR;
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

// ----- hw/rtl/bitmap_range_engine.sv -----
// Range set, clear and population count over a bitmap of BITMAP_BITS bits, index 0
// being the most significant bit of byte 0. A command is taken when start is high and
// busy is low; each command gives exactly one result, shown on out_result for one cycle
// with out_valid high, and the receiver must take it then since it cannot stall. A
// command walks its range one memory byte per cycle; commands with nothing to do are
// answered at pickup without reading the memory. A holding stage and a two-entry queue
// let up to three further commands be taken while one is worked on. After reset the
// memory (512 bytes at the default size, at most 1536) is swept to zero, one byte a
// cycle, and busy stays high until the sweep is done.
module bitmap_range_engine #(
  parameter int BITMAP_BITS = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  brg_pkg::brg_in_t  in_item,
  output logic              out_valid,
  output brg_pkg::brg_out_t out_result
);
  import brg_pkg::*;

  logic         in_xfer;
  logic         push;
  logic         stage_busy;
  logic         pop;
  logic         clearing;
  brg_desc_t    front_desc;
  brg_desc_t    head_desc;
  brg_q_stat_t  q_stat;

  assign busy    = clearing || stage_busy;
  assign in_xfer = start && !busy;

  // Classify commands and clip ranges.
  brg_front #(
    .BITMAP_BITS(BITMAP_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_xfer),
    .in_item   (in_item),
    .q_stat    (q_stat),
    .push      (push),
    .stage_busy(stage_busy),
    .desc      (front_desc)
  );

  // Decoupling queue.
  brg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_desc(front_desc),
    .pop      (pop),
    .head_desc(head_desc),
    .q_stat   (q_stat)
  );

  // Memory walk and result.
  brg_back #(
    .BITMAP_BITS(BITMAP_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head_desc (head_desc),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_result(out_result)
  );

  // Checks on the internal hand-offs.
  `include "bitmap_range_engine_assert.svh"

  `BRG_ASSERT_IMPLY(a_no_result_in_clear, clk, rst_n, clearing, !out_valid, "result in clear")
  `BRG_ASSERT_IMPLY(a_no_push_when_full, clk, rst_n, push, !q_stat.full, "push into full queue")
  `BRG_ASSERT_NEXT(a_push_fills_queue, clk, rst_n, push, !q_stat.empty, "queue empty after push")
  `BRG_ASSERT_IMPLY(a_total_bound, clk, rst_n, out_valid, int'(out_result.bit_total) <= BITMAP_BITS, "total")

endmodule
